// ===== hdl/ptdq_pkg.sv =====
`default_nettype none
// ============================================================================
// ptdq_pkg
// Shared types and constants for the pose to dual quaternion converter.
// ============================================================================
package ptdq_pkg;

    // Fixed-point formats
    localparam int QUAT_FRAC_BITS = 14;
    localparam logic signed [15:0] QUAT_ONE = 16'(32'd1 << QUAT_FRAC_BITS);

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;                 // power of two
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Multiply-accumulate datapath
    localparam int LANES     = 4;
    localparam int MUL_A_W   = 36;                 // holds 32-bit inputs and aux terms
    localparam int PROD_W    = MUL_A_W + 16;
    localparam int ACC_W     = PROD_W + 2;         // sum of up to four products
    localparam int STEP_W    = 4;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd13;

    // Component selectors
    localparam logic [1:0] IDX_W = 2'd0;
    localparam logic [1:0] IDX_X = 2'd1;
    localparam logic [1:0] IDX_Y = 2'd2;
    localparam logic [1:0] IDX_Z = 2'd3;
    localparam logic [1:0] VEC_X = 2'd0;
    localparam logic [1:0] VEC_Y = 2'd1;
    localparam logic [1:0] VEC_Z = 2'd2;

    // One odometry sample
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_in_item;

    // One result
    typedef struct packed {
        logic signed [15:0] real_w;
        logic signed [15:0] real_x;
        logic signed [15:0] real_y;
        logic signed [15:0] real_z;
        logic signed [31:0] dual_w;
        logic signed [31:0] dual_x;
        logic signed [31:0] dual_y;
        logic signed [31:0] dual_z;
        logic signed [31:0] body_vel_x;
        logic signed [31:0] body_vel_y;
        logic signed [31:0] body_vel_z;
    } t_out_item;

    // Which product group a MAC step belongs to
    typedef enum logic [1:0] {
        KIND_DUAL,
        KIND_AUX,
        KIND_BODY
    } t_kind;

    typedef struct packed {
        logic [1:0] a_idx;
        logic [1:0] b_idx;
        logic       neg;
    } t_mac_op;

    typedef struct packed {
        logic                  issue;
        logic                  first;
        logic                  last;
        t_kind                 kind;
        t_mac_op [LANES-1:0]   op;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } t_back_state;

endpackage
`default_nettype wire

// ===== hdl/pose_to_dual_quaternion_top.sv =====
`default_nettype none
// ============================================================================
// pose_to_dual_quaternion_top
// Converts odometry samples to unit dual quaternions plus body-frame velocity.
// ============================================================================
// Each pushed sample gives exactly one result, in order. The front holds one
// sample and corrects its quaternion sign against the previous output
// combinationally, so it takes a new sample every cycle while the two-entry
// queue has room. The back loads a sample, runs fourteen steps of four shared
// multiply-accumulate lanes covering 36 products with a rounding pass between
// the velocity stages, and hands the result to the output register. It takes
// the next sample from the queue only after that hand-off, which waits while
// the output register holds a result that is not being popped. A finished
// result waits in the output register while the next sample is computed.
// Quaternions are Q2.14, position and velocity Q16.16; outputs saturate.
// ============================================================================
module pose_to_dual_quaternion_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ptdq_pkg::t_in_item  i_data,
    input  wire logic                pop,
    output logic                     empty,
    output ptdq_pkg::t_out_item      o_data
);

    logic                q_push;
    logic                q_full;
    ptdq_pkg::t_in_item  q_wdata;
    logic                q_pop;
    logic                q_empty;
    ptdq_pkg::t_in_item  q_rdata;

    // Sign continuity
    ptdq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_data   (i_data),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    // Decoupling queue
    ptdq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Arithmetic and output register
    ptdq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_data    (o_data),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule
`default_nettype wire

// ===== hdl/ptdq_front.sv =====
`default_nettype none
// ============================================================================
// ptdq_front
// Holds one incoming sample and fixes its quaternion sign against the
// previous output quaternion before handing it to the queue.
// ============================================================================
module ptdq_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire ptdq_pkg::t_in_item  i_data,
    output logic                     o_q_push,
    output ptdq_pkg::t_in_item       o_q_data,
    input  wire logic                i_q_full
);

    // Saturating negate of a Q2.14 component
    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == 16'sh8000) begin
            r = 16'sh7fff;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    ptdq_pkg::t_in_item  r_hold;
    logic                r_hold_v;
    logic signed [15:0]  r_prev [4];
    logic                r_prev_v;

    logic signed [15:0]  q_in  [4];
    logic signed [15:0]  q_cls [4];
    logic signed [31:0]  prod  [4];
    logic signed [33:0]  dot;
    logic                flip;
    logic                accept;

    // Handshake: the held transaction moves on whenever the queue has room
    assign o_q_push = r_hold_v && !i_q_full;
    assign o_full   = r_hold_v && i_q_full;
    assign accept   = i_push && !o_full;

    // Sign continuity against the last output quaternion
    always_comb begin
        q_in[0] = r_hold.quat_w;
        q_in[1] = r_hold.quat_x;
        q_in[2] = r_hold.quat_y;
        q_in[3] = r_hold.quat_z;
        for (int i = 0; i < 4; i++) begin
            prod[i] = q_in[i] * r_prev[i];
        end
        dot  = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);
        flip = r_prev_v && dot[33];
        for (int i = 0; i < 4; i++) begin
            q_cls[i] = flip ? neg_sat16(q_in[i]) : q_in[i];
        end
    end

    always_comb begin
        o_q_data        = r_hold;
        o_q_data.quat_w = q_cls[0];
        o_q_data.quat_x = q_cls[1];
        o_q_data.quat_y = q_cls[2];
        o_q_data.quat_z = q_cls[3];
    end

    // Holding register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold <= i_data;
        end
    end

    // Control and reference quaternion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v  <= 1'b0;
            r_prev_v  <= 1'b0;
            r_prev[0] <= ptdq_pkg::QUAT_ONE;
            r_prev[1] <= '0;
            r_prev[2] <= '0;
            r_prev[3] <= '0;
        end else begin
            if (accept) begin
                r_hold_v <= 1'b1;
            end else if (o_q_push) begin
                r_hold_v <= 1'b0;
            end
            if (o_q_push) begin
                r_prev_v <= 1'b1;
                for (int i = 0; i < 4; i++) begin
                    r_prev[i] <= q_cls[i];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ptdq_fifo.sv =====
`default_nettype none
// ============================================================================
// ptdq_fifo
// Short queue of sign-corrected samples between the front and back parts.
// ============================================================================
module ptdq_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire ptdq_pkg::t_in_item  i_data,
    output logic                     o_full,
    input  wire logic                i_pop,
    output ptdq_pkg::t_in_item       o_data,
    output logic                     o_empty
);

    ptdq_pkg::t_in_item                    r_mem [ptdq_pkg::FIFO_DEPTH];
    logic [ptdq_pkg::FIFO_PTR_W-1:0]       r_wr_ptr;
    logic [ptdq_pkg::FIFO_PTR_W-1:0]       r_rd_ptr;
    logic [ptdq_pkg::FIFO_CNT_W-1:0]       r_count;
    logic                                  do_push;
    logic                                  do_pop;

    assign o_full  = (r_count == ptdq_pkg::FIFO_CNT_W'(ptdq_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ptdq_back.sv =====
`default_nettype none
// ============================================================================
// ptdq_back
// Four multiply-accumulate lanes stepped by a fixed schedule: dual part,
// then aux = conj(q)(0,v), then the body-frame velocity from aux and q.
// ============================================================================
module ptdq_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ptdq_pkg::t_in_item  i_q_data,
    input  wire logic                i_q_empty,
    output logic                     o_q_pop,
    output ptdq_pkg::t_out_item      o_data,
    output logic                     o_empty,
    input  wire logic                i_pop
);

    localparam int LANES  = ptdq_pkg::LANES;
    localparam int A_W    = ptdq_pkg::MUL_A_W;
    localparam int PROD_W = ptdq_pkg::PROD_W;
    localparam int ACC_W  = ptdq_pkg::ACC_W;
    localparam int QFB    = ptdq_pkg::QUAT_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF_Q = ACC_W'(1) << (QFB - 1);
    localparam logic signed [ACC_W-1:0] HALF_D = ACC_W'(1) << QFB;

    function automatic ptdq_pkg::t_mac_op mk_op(input logic [1:0] a, input logic [1:0] b,
                                                input logic n);
        ptdq_pkg::t_mac_op o;
        o.a_idx = a;
        o.b_idx = b;
        o.neg   = n;
        return o;
    endfunction

    // Per-step lane operations; lane 3 is unused in the body group
    function automatic ptdq_pkg::t_mac_ctl mac_sched(input logic [ptdq_pkg::STEP_W-1:0] k);
        ptdq_pkg::t_mac_ctl c;
        c.issue = 1'b1;
        c.first = 1'b0;
        c.last  = 1'b0;
        c.kind  = ptdq_pkg::KIND_DUAL;
        c.op    = '0;
        case (k)
            4'd0: begin
                c.first = 1'b1;
                c.op[0] = mk_op(ptdq_pkg::VEC_X, ptdq_pkg::IDX_X, 1'b1);
                c.op[1] = mk_op(ptdq_pkg::VEC_X, ptdq_pkg::IDX_W, 1'b0);
                c.op[2] = mk_op(ptdq_pkg::VEC_Y, ptdq_pkg::IDX_W, 1'b0);
                c.op[3] = mk_op(ptdq_pkg::VEC_Z, ptdq_pkg::IDX_W, 1'b0);
            end
            4'd1: begin
                c.op[0] = mk_op(ptdq_pkg::VEC_Y, ptdq_pkg::IDX_Y, 1'b1);
                c.op[1] = mk_op(ptdq_pkg::VEC_Z, ptdq_pkg::IDX_Y, 1'b1);
                c.op[2] = mk_op(ptdq_pkg::VEC_Z, ptdq_pkg::IDX_X, 1'b0);
                c.op[3] = mk_op(ptdq_pkg::VEC_Y, ptdq_pkg::IDX_X, 1'b1);
            end
            4'd2: begin
                c.last  = 1'b1;
                c.op[0] = mk_op(ptdq_pkg::VEC_Z, ptdq_pkg::IDX_Z, 1'b1);
                c.op[1] = mk_op(ptdq_pkg::VEC_Y, ptdq_pkg::IDX_Z, 1'b0);
                c.op[2] = mk_op(ptdq_pkg::VEC_X, ptdq_pkg::IDX_Z, 1'b1);
                c.op[3] = mk_op(ptdq_pkg::VEC_X, ptdq_pkg::IDX_Y, 1'b0);
            end
            4'd3: begin
                c.kind  = ptdq_pkg::KIND_AUX;
                c.first = 1'b1;
                c.op[0] = mk_op(ptdq_pkg::VEC_X, ptdq_pkg::IDX_X, 1'b0);
                c.op[1] = mk_op(ptdq_pkg::VEC_X, ptdq_pkg::IDX_W, 1'b0);
                c.op[2] = mk_op(ptdq_pkg::VEC_X, ptdq_pkg::IDX_Z, 1'b1);
                c.op[3] = mk_op(ptdq_pkg::VEC_X, ptdq_pkg::IDX_Y, 1'b0);
            end
            4'd4: begin
                c.kind  = ptdq_pkg::KIND_AUX;
                c.op[0] = mk_op(ptdq_pkg::VEC_Y, ptdq_pkg::IDX_Y, 1'b0);
                c.op[1] = mk_op(ptdq_pkg::VEC_Y, ptdq_pkg::IDX_Z, 1'b0);
                c.op[2] = mk_op(ptdq_pkg::VEC_Y, ptdq_pkg::IDX_W, 1'b0);
                c.op[3] = mk_op(ptdq_pkg::VEC_Y, ptdq_pkg::IDX_X, 1'b1);
            end
            4'd5: begin
                c.kind  = ptdq_pkg::KIND_AUX;
                c.last  = 1'b1;
                c.op[0] = mk_op(ptdq_pkg::VEC_Z, ptdq_pkg::IDX_Z, 1'b0);
                c.op[1] = mk_op(ptdq_pkg::VEC_Z, ptdq_pkg::IDX_Y, 1'b1);
                c.op[2] = mk_op(ptdq_pkg::VEC_Z, ptdq_pkg::IDX_X, 1'b0);
                c.op[3] = mk_op(ptdq_pkg::VEC_Z, ptdq_pkg::IDX_W, 1'b0);
            end
            // two empty steps: aux terms are rounded before the body group reads them
            4'd8: begin
                c.kind  = ptdq_pkg::KIND_BODY;
                c.first = 1'b1;
                c.op[0] = mk_op(ptdq_pkg::IDX_X, ptdq_pkg::IDX_W, 1'b0);
                c.op[1] = mk_op(ptdq_pkg::IDX_Y, ptdq_pkg::IDX_W, 1'b0);
                c.op[2] = mk_op(ptdq_pkg::IDX_Z, ptdq_pkg::IDX_W, 1'b0);
            end
            4'd9: begin
                c.kind  = ptdq_pkg::KIND_BODY;
                c.op[0] = mk_op(ptdq_pkg::IDX_W, ptdq_pkg::IDX_X, 1'b0);
                c.op[1] = mk_op(ptdq_pkg::IDX_Z, ptdq_pkg::IDX_X, 1'b0);
                c.op[2] = mk_op(ptdq_pkg::IDX_Y, ptdq_pkg::IDX_X, 1'b1);
            end
            4'd10: begin
                c.kind  = ptdq_pkg::KIND_BODY;
                c.op[0] = mk_op(ptdq_pkg::IDX_Z, ptdq_pkg::IDX_Y, 1'b1);
                c.op[1] = mk_op(ptdq_pkg::IDX_W, ptdq_pkg::IDX_Y, 1'b0);
                c.op[2] = mk_op(ptdq_pkg::IDX_X, ptdq_pkg::IDX_Y, 1'b0);
            end
            4'd11: begin
                c.kind  = ptdq_pkg::KIND_BODY;
                c.last  = 1'b1;
                c.op[0] = mk_op(ptdq_pkg::IDX_Y, ptdq_pkg::IDX_Z, 1'b0);
                c.op[1] = mk_op(ptdq_pkg::IDX_X, ptdq_pkg::IDX_Z, 1'b1);
                c.op[2] = mk_op(ptdq_pkg::IDX_W, ptdq_pkg::IDX_Z, 1'b0);
            end
            default: begin
                c.issue = 1'b0;
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sel_vec(input logic [1:0] idx,
                                                   input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] z);
        logic signed [31:0] r;
        case (idx)
            ptdq_pkg::VEC_X: r = x;
            ptdq_pkg::VEC_Y: r = y;
            ptdq_pkg::VEC_Z: r = z;
            default:         r = '0;
        endcase
        return r;
    endfunction

    // Saturate an accumulator-wide value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
            r = v[31:0];
        end else if (v[ACC_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    ptdq_pkg::t_back_state            r_state;
    ptdq_pkg::t_back_state            n_state;
    logic [ptdq_pkg::STEP_W-1:0]      r_step;
    ptdq_pkg::t_in_item               r_cur;
    ptdq_pkg::t_mac_ctl               n_ctl;
    ptdq_pkg::t_mac_ctl               r_ctl;
    logic                             r_fin_v;
    ptdq_pkg::t_kind                  r_fin_kind;
    logic signed [A_W-1:0]            op_a   [LANES];
    logic signed [15:0]               op_b   [LANES];
    logic signed [PROD_W-1:0]         n_prod [LANES];
    logic signed [PROD_W-1:0]         r_prod [LANES];
    logic signed [ACC_W-1:0]          term   [LANES];
    logic signed [ACC_W-1:0]          n_acc  [LANES];
    logic signed [ACC_W-1:0]          r_acc  [LANES];
    logic signed [ACC_W-1:0]          rnd_d  [LANES];
    logic signed [ACC_W-1:0]          rnd_q  [LANES];
    logic signed [A_W-1:0]            r_aux  [4];
    logic signed [31:0]               r_dual [4];
    logic signed [31:0]               r_body [3];
    ptdq_pkg::t_out_item              r_out;
    logic                             r_ov;
    logic                             start;
    logic                             load_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptdq_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ptdq_pkg::BK_RUN;
                end
            end
            ptdq_pkg::BK_RUN: begin
                if (r_step == ptdq_pkg::STEP_LAST) begin
                    n_state = ptdq_pkg::BK_DONE;
                end
            end
            ptdq_pkg::BK_DONE: begin
                if (!r_ov || i_pop) begin
                    n_state = ptdq_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ptdq_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        start    = 1'b0;
        load_out = 1'b0;
        n_ctl    = mac_sched(r_step);
        case (r_state)
            ptdq_pkg::BK_IDLE: begin
                start       = !i_q_empty;
                n_ctl.issue = 1'b0;
            end
            ptdq_pkg::BK_RUN: begin
            end
            ptdq_pkg::BK_DONE: begin
                load_out    = !r_ov || i_pop;
                n_ctl.issue = 1'b0;
            end
            default: begin
                n_ctl.issue = 1'b0;
            end
        endcase
    end

    assign o_q_pop = start;
    assign o_empty = !r_ov;
    assign o_data  = r_out;

    // Operand selection and multipliers
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            case (n_ctl.kind)
                ptdq_pkg::KIND_DUAL: op_a[l] = A_W'(sel_vec(n_ctl.op[l].a_idx,
                                                   r_cur.pos_x, r_cur.pos_y, r_cur.pos_z));
                ptdq_pkg::KIND_AUX:  op_a[l] = A_W'(sel_vec(n_ctl.op[l].a_idx,
                                                   r_cur.vel_x, r_cur.vel_y, r_cur.vel_z));
                ptdq_pkg::KIND_BODY: op_a[l] = r_aux[n_ctl.op[l].a_idx];
                default:             op_a[l] = '0;
            endcase
            case (n_ctl.op[l].b_idx)
                ptdq_pkg::IDX_W: op_b[l] = r_cur.quat_w;
                ptdq_pkg::IDX_X: op_b[l] = r_cur.quat_x;
                ptdq_pkg::IDX_Y: op_b[l] = r_cur.quat_y;
                ptdq_pkg::IDX_Z: op_b[l] = r_cur.quat_z;
                default:         op_b[l] = '0;
            endcase
            n_prod[l] = op_a[l] * op_b[l];
        end
    end

    // Accumulate the registered products
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            term[l] = r_ctl.op[l].neg ? -ACC_W'(r_prod[l]) : ACC_W'(r_prod[l]);
            if (!r_ctl.issue) begin
                n_acc[l] = r_acc[l];
            end else if (r_ctl.first) begin
                n_acc[l] = term[l];
            end else begin
                n_acc[l] = r_acc[l] + term[l];
            end
            // round half up: dual part takes one more bit for the factor 0.5
            rnd_d[l] = (r_acc[l] + HALF_D) >>> (QFB + 1);
            rnd_q[l] = (r_acc[l] + HALF_Q) >>> QFB;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cur <= i_q_data;
        end
        for (int l = 0; l < LANES; l++) begin
            r_prod[l] <= n_prod[l];
            r_acc[l]  <= n_acc[l];
        end
        if (r_fin_v) begin
            case (r_fin_kind)
                ptdq_pkg::KIND_DUAL: begin
                    for (int l = 0; l < 4; l++) begin
                        r_dual[l] <= sat32(rnd_d[l]);
                    end
                end
                ptdq_pkg::KIND_AUX: begin
                    for (int l = 0; l < 4; l++) begin
                        r_aux[l] <= rnd_q[l][A_W-1:0];
                    end
                end
                ptdq_pkg::KIND_BODY: begin
                    for (int l = 0; l < 3; l++) begin
                        r_body[l] <= sat32(rnd_q[l]);
                    end
                end
                default: begin
                end
            endcase
        end
        if (load_out) begin
            r_out.real_w     <= r_cur.quat_w;
            r_out.real_x     <= r_cur.quat_x;
            r_out.real_y     <= r_cur.quat_y;
            r_out.real_z     <= r_cur.quat_z;
            r_out.dual_w     <= r_dual[0];
            r_out.dual_x     <= r_dual[1];
            r_out.dual_y     <= r_dual[2];
            r_out.dual_z     <= r_dual[3];
            r_out.body_vel_x <= r_body[0];
            r_out.body_vel_y <= r_body[1];
            r_out.body_vel_z <= r_body[2];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ptdq_pkg::BK_IDLE;
            r_step     <= '0;
            r_ctl      <= '0;
            r_fin_v    <= 1'b0;
            r_fin_kind <= ptdq_pkg::KIND_DUAL;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= (r_state == ptdq_pkg::BK_RUN) ? r_step + 1'b1 : '0;
            r_ctl      <= n_ctl;
            r_fin_v    <= r_ctl.issue && r_ctl.last;
            r_fin_kind <= r_ctl.kind;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
